>>> rtl/core/slcan_pkg.sv
// Shared types, constants and the per-position character function of the SLCAN encoder.
`timescale 1ns / 1ps
package slcan_pkg;

  // Longest line: 'T', eight id digits, the length digit and sixteen data digits.
  localparam int N_CHARS = 26;
  // One spare cell so that a new line can load behind a character still waiting.
  localparam int N_CELLS = N_CHARS + 1;
  localparam int IN_W    = 104;

  localparam logic [28:0] STD_ID_MAX = 29'h7FF;
  localparam logic [3:0]  MAX_BYTES  = 4'd8;

  localparam logic [7:0] CH_STD   = 8'h74;  // 't'
  localparam logic [7:0] CH_EXT   = 8'h54;  // 'T'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_ALPHA = 8'h37;  // 'A' minus ten

  // One character held in a cell of the output chain.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       valid;
  } cell_data_t;

  // Per-cell control from the chain controller.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // Uppercase hex digit of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (CH_ZERO + {4'b0, nib}) : (CH_ALPHA + {4'b0, nib});
  endfunction

  // Character at line position p of the frame (id, length, data).
  function automatic cell_data_t enc_char(input logic [5:0]  p,
                                          input logic [28:0] id,
                                          input logic [3:0]  len_in,
                                          input logic [63:0] data);
    cell_data_t  r;
    logic        ext;
    logic [3:0]  len;
    logic [5:0]  nd;
    logic [5:0]  sh;
    logic [5:0]  q;
    logic [5:0]  total;
    logic [31:0] id_ext;
    logic [7:0]  byte_v;
    logic [3:0]  nib;
    ext    = (id > STD_ID_MAX);
    len    = (len_in > MAX_BYTES) ? MAX_BYTES : len_in;
    nd     = ext ? 6'd8 : 6'd3;
    total  = nd + 6'd2 + {1'b0, len, 1'b0};
    id_ext = {3'b000, id};
    sh     = nd - p;
    q      = p - nd - 6'd2;
    byte_v = data[{q[3:1], 3'b000} +: 8];
    nib    = q[0] ? byte_v[3:0] : byte_v[7:4];
    r.last  = (p == total - 6'd1);
    r.valid = (p < total);
    // Type letter, id digits most significant first, length digit, then data digits.
    if (p == 6'd0) begin
      r.ch = ext ? CH_EXT : CH_STD;
    end else if (p <= nd) begin
      r.ch = hex_char(id_ext[{sh[2:0], 2'b00} +: 4]);
    end else if (p == nd + 6'd1) begin
      r.ch = CH_ZERO + {4'b0, len};
    end else begin
      r.ch = hex_char(nib);
    end
    enc_char = r;
  endfunction

endpackage

>>> rtl/core/slcan_cell.sv
// One cell of the output character chain.
`timescale 1ns / 1ps
module slcan_cell import slcan_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  cell_data_t load_data,  // character of a newly accepted frame
  input  cell_data_t nbr,        // character from the next cell up the chain
  output cell_data_t q
);

  cell_data_t q_next;

  // Load a new character, take the neighbor's, or hold.
  always_comb begin
    if (ctrl.load) begin
      q_next = load_data;
    end else if (ctrl.shift) begin
      q_next = nbr;
    end else begin
      q_next = q;
    end
  end

  // Valid flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= q_next.valid;
    end
  end

  // Character and last flag need no reset.
  always_ff @(posedge clk) begin
    q.ch   <= q_next.ch;
    q.last <= q_next.last;
  end

endmodule

>>> rtl/core/slcan_fmt.sv
// Frame formatter: works out every character position of the SLCAN line at once.
`timescale 1ns / 1ps
module slcan_fmt import slcan_pkg::*; (
  input  logic [28:0] can_id,
  input  logic [3:0]  length,
  input  logic [63:0] payload,
  output cell_data_t  chars [N_CHARS]
);

  // Each position is decoded on its own from the frame fields.
  for (genvar i = 0; i < N_CHARS; i++) begin : g_pos
    assign chars[i] = enc_char(6'(i), can_id, length, payload);
  end

endmodule

>>> rtl/core/slcan_frame_text_encoder.sv
// Top level of the SLCAN frame text encoder: formatter and output cell chain.
`timescale 1ns / 1ps
// A frame accepted on the slave side is turned into its SLCAN line, which is
// loaded in parallel into a chain of character cells and leaves at the head
// of the chain one character per transaction, the final one marked by tlast.
// A standard frame (id up to 0x7FF) gives 5 to 21 characters, an extended
// frame 10 to 26. The slave side is ready as soon as the chain holds at most
// one character, so the next frame loads behind the last character of the
// previous line even while that character waits on the master side; with no
// stalls, lines follow one another back to back. Length values above 8 send
// 8 bytes.
module slcan_frame_text_encoder import slcan_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // can_id[28:0], length[32:29], payload[96:33], zeros
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // text_char[7:0]
  output logic              m_tlast
);

  cell_data_t chars [N_CHARS];
  cell_data_t q     [N_CELLS];
  cell_data_t load_d [N_CELLS];
  cell_data_t nbr_d  [N_CELLS];
  cell_ctrl_t ctrl  [N_CELLS];
  logic       load;
  logic       hold_head;
  logic       shift;

  slcan_fmt u_fmt (
    .can_id  (s_tdata[28:0]),
    .length  (s_tdata[32:29]),
    .payload (s_tdata[96:33]),
    .chars   (chars)
  );

  // Chain control: a new frame may enter once cell one is empty.
  assign s_tready  = !q[1].valid;
  assign load      = s_tvalid && s_tready;
  assign shift     = !q[0].valid || m_tready;
  assign hold_head = q[0].valid && !m_tready;

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    // Neighbor data; the top cell takes in an empty slot.
    if (k == N_CELLS - 1) begin : g_top
      assign nbr_d[k] = '0;
    end else begin : g_mid
      assign nbr_d[k] = q[k+1];
    end

    // Load data: line starts at cell zero, or at cell one behind a waiting character.
    if (k == 0) begin : g_ld0
      assign load_d[k]    = chars[0];
      assign ctrl[k].load = load && !hold_head;
    end else if (k == N_CELLS - 1) begin : g_ldt
      assign load_d[k]    = hold_head ? chars[k-1] : cell_data_t'('0);
      assign ctrl[k].load = load;
    end else begin : g_ldm
      assign load_d[k]    = hold_head ? chars[k-1] : chars[k];
      assign ctrl[k].load = load;
    end
    assign ctrl[k].shift = shift;

    slcan_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl[k]),
      .load_data (load_d[k]),
      .nbr       (nbr_d[k]),
      .q         (q[k])
    );
  end

  // Head of the chain drives the master side.
  assign m_tvalid = q[0].valid;
  assign m_tdata  = q[0].ch;
  assign m_tlast  = q[0].last;

  // The chain fills from the head with no gaps.
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    q[1].valid |-> q[0].valid)
    else $error("chain has a gap behind an empty head cell");

  // An accepted frame shows a character in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted frame produced no character");

  // A line never breaks before its final character.
  a_line_whole: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("line text broke before its last character");

  // No frame is taken while cells one and two both hold a character.
  a_ready_gate: assert property (@(posedge clk) disable iff (rst)
    (q[1].valid && q[2].valid) |-> !s_tready)
    else $error("ready raised while the chain still held a line");

endmodule

>>> verif/slcan_frame_text_encoder_tb.sv
// Self-checking testbench for the SLCAN frame text encoder.
`timescale 1ns / 1ps
// CAN frames go in on the slave stream. A behavioral encoder in this file
// predicts the ASCII characters of each frame's line. A monitor on the master
// stream compares every character and its tlast flag, in order. Both sides
// stall at random. One stretch runs with no stalls, one has a long receiver
// hold-off, and one pauses the sender until the output has drained.
module slcan_frame_text_encoder_tb;
  import slcan_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RX_HOLD_LEN  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 35;

  // One character of an SLCAN line, as it should leave the master side.
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } line_char_t;

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata;
  logic            m_tvalid;
  logic            m_tready;
  logic [7:0]      m_tdata;
  logic            m_tlast;

  line_char_t line_chars_q[$];
  int         idle_pct;
  bit         rx_hold_req;
  int         cycle_cnt;
  int         err_cnt;
  int         frames_sent;
  int         ext_frames;
  int         sat_frames;
  int         chars_checked;

  slcan_frame_text_encoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Clock generation: 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Uppercase hex digit of one nibble.
  function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
    nibble_ascii = (nib < 4'd10) ? (CH_ZERO + {4'b0, nib}) : (CH_ALPHA + {4'b0, nib});
  endfunction

  // Build the SLCAN line of one frame and queue its characters.
  function automatic void encode_line(input logic [28:0] id, input logic [3:0] len_raw,
                                      input logic [63:0] data);
    logic [7:0]  txt [N_CHARS];
    logic [31:0] id_wide;
    logic [3:0]  nbytes;
    logic [7:0]  byte_v;
    int          n;
    int          ndig;
    int          k;
    nbytes  = (len_raw > MAX_BYTES) ? MAX_BYTES : len_raw;
    id_wide = {3'b000, id};
    n       = 0;
    if (id > STD_ID_MAX) begin
      txt[n] = CH_EXT;
      ndig   = 8;
    end else begin
      txt[n] = CH_STD;
      ndig   = 3;
    end
    n++;
    // Identifier digits, most significant first.
    for (k = ndig - 1; k >= 0; k--) begin
      txt[n] = nibble_ascii(id_wide[4*k +: 4]);
      n++;
    end
    txt[n] = CH_ZERO + {4'b0, nbytes};
    n++;
    // Data bytes, byte 0 first, high nibble first.
    for (k = 0; k < nbytes; k++) begin
      byte_v     = data[8*k +: 8];
      txt[n]     = nibble_ascii(byte_v[7:4]);
      txt[n + 1] = nibble_ascii(byte_v[3:0]);
      n += 2;
    end
    for (k = 0; k < n; k++) begin
      line_chars_q.push_back('{ch: txt[k], last: (k == n - 1)});
    end
  endfunction

  // Offer one frame after a random gap and wait for its transaction.
  task automatic send_frame(input logic [28:0] id, input logic [3:0] len,
                            input logic [63:0] data);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, data, len, id};
    do @(posedge clk); while (!s_tready);
    encode_line(id, len, data);
    frames_sent++;
    if (id > STD_ID_MAX) ext_frames++;
    if (len > MAX_BYTES) sat_frames++;
  endtask

  // Random frame: standard and extended ids in equal share, a few long lengths.
  task automatic send_random_frame();
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] data;
    if ($urandom_range(1) == 0) id = 29'($urandom_range(2047));
    else                        id = 29'($urandom);
    if ($urandom_range(9) == 0) len = 4'($urandom_range(15, 9));
    else                        len = 4'($urandom_range(8));
    data = {$urandom, $urandom};
    send_frame(id, len, data);
  endtask

  // Withdraw the offer after the last accepted frame.
  task automatic stop_offering();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_drain();
    while (line_chars_q.size() != 0) @(posedge clk);
  endtask

  // Id boundaries, every length, saturated lengths and all hex digits.
  task automatic test_directed();
    send_frame(29'h0, 4'd0, 64'h0);
    send_frame(29'h7FF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(29'h800, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_frame(29'h1FFF_FFFF, 4'd8, 64'hFEDC_BA98_7654_3210);
    send_frame(29'h1FFF_FFFF, 4'd0, 64'h0);
    send_frame(29'h123, 4'd1, 64'hFFFF_FFFF_FFFF_FF5A);
    send_frame(29'h456, 4'd2, 64'hAAAA_AAAA_AAAA_C3B2);
    send_frame(29'h789, 4'd3, 64'h5555_5555_5512_3456);
    send_frame(29'h0ABC_DEF0, 4'd4, 64'hDEAD_BEEF_0F1E_2D3C);
    send_frame(29'h0000_1000, 4'd5, 64'h0000_0099_8877_6655);
    send_frame(29'h1555_5555, 4'd6, 64'h1122_3344_5566_7788);
    send_frame(29'h0AAA_AAAA, 4'd7, 64'h8000_0000_0000_0001);
    send_frame(29'h7FE, 4'd9, 64'h0F0F_0F0F_0F0F_0F0F);
    send_frame(29'h801, 4'd15, 64'hF0F0_F0F0_F0F0_F0F0);
    send_frame(29'h3C5, 4'd12, 64'h9876_5432_10FE_DCBA);
    send_frame(29'h0, 4'd8, 64'h0);
    send_frame(29'h1000_0000, 4'd1, 64'h0000_0000_0000_0080);
  endtask

  task automatic test_random(input int count);
    int i;
    for (i = 0; i < count; i++) send_random_frame();
  endtask

  // Back-to-back frames and characters with neither side stalling.
  task automatic test_full_rate(input int count);
    int i;
    idle_pct = 0;
    for (i = 0; i < count; i++) send_random_frame();
    idle_pct = IDLE_PCT;
  endtask

  // Receiver holds off for a long stretch while frames keep coming.
  task automatic test_backpressure(input int count);
    int i;
    rx_hold_req = 1'b1;
    for (i = 0; i < count; i++) send_random_frame();
  endtask

  // Sender waits for an empty pipeline before the next few frames.
  task automatic test_drain_pause(input int count);
    int i;
    stop_offering();
    wait_for_drain();
    for (i = 0; i < count; i++) send_random_frame();
  endtask

  // Receiver: random stalls, or one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (RX_HOLD_LEN) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Compare each output transaction with the oldest predicted character.
  always @(posedge clk) begin
    line_char_t exp_c;
    if (!rst && m_tvalid && m_tready) begin
      if (line_chars_q.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $time, m_tdata, m_tlast);
        err_cnt++;
      end else begin
        exp_c = line_chars_q.pop_front();
        chars_checked++;
        if (m_tdata !== exp_c.ch) begin
          $display("%0t: text_char mismatch: expected %h, actual %h",
                   $time, exp_c.ch, m_tdata);
          err_cnt++;
        end
        if (m_tlast !== exp_c.last) begin
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, exp_c.last, m_tlast);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d characters outstanding", $time, line_chars_q.size());
      $display("slcan_frame_text_encoder_tb NOT OK");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    idle_pct      = IDLE_PCT;
    rx_hold_req   = 1'b0;
    cycle_cnt     = 0;
    err_cnt       = 0;
    frames_sent   = 0;
    ext_frames    = 0;
    sat_frames    = 0;
    chars_checked = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(150);
    test_full_rate(40);
    test_backpressure(8);
    test_random(150);
    test_drain_pause(6);

    stop_offering();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (line_chars_q.size() != 0) begin
      $display("%0t: %0d predicted characters never arrived", $time, line_chars_q.size());
      err_cnt++;
    end

    $display("Sent %0d frames (%0d extended, %0d with length above eight), checked %0d chars.",
             frames_sent, ext_frames, sat_frames, chars_checked);
    $display("Covered random stalls, a full-rate stretch, a long output hold-off and a drain.");
    if (err_cnt == 0) begin
      $display("slcan_frame_text_encoder_tb OK");
    end else begin
      $display("slcan_frame_text_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule
